/* design/assert_macros.svh */
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

/* design/tknd_pkg.sv */
package tknd_pkg;

  localparam logic [8:0] K_INSERT = 9'd256;
  localparam logic [8:0] K_DELETE = 9'd257;
  localparam logic [8:0] K_HOME   = 9'd258;
  localparam logic [8:0] K_END    = 9'd259;
  localparam logic [8:0] K_PGUP   = 9'd260;
  localparam logic [8:0] K_PGDN   = 9'd261;
  localparam logic [8:0] K_UP     = 9'd262;
  localparam logic [8:0] K_DOWN   = 9'd263;
  localparam logic [8:0] K_RIGHT  = 9'd264;
  localparam logic [8:0] K_LEFT   = 9'd265;
  localparam logic [8:0] K_TAB    = 9'd266;
  localparam logic [8:0] K_ESCAPE = 9'd267;
  localparam logic [8:0] K_F1     = 9'd268;

  localparam logic KIND_KEY    = 1'b0;
  localparam logic KIND_RESIZE = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // mods: bit 0 shift, bit 1 alt, bit 2 ctrl
  typedef struct packed {
    logic        kind;
    logic [8:0]  key;
    logic [2:0]  mods;
    logic [15:0] width;
    logic [15:0] height;
  } tknd_event_t;

  // esc: an escape key goes out ahead of the main event
  typedef struct packed {
    logic        esc;
    logic        main;
    tknd_event_t ev;
  } tknd_entry_t;

endpackage

/* design/tknd_queue.sv */
`include "assert_macros.svh"

module tknd_queue import tknd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  tknd_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output tknd_entry_t head,
  output logic        empty
);

  tknd_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full, "queue written while full")
  `ASSERT_NEXT(a_fill_step, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue fill count slipped")

endmodule

/* design/tknd_front.sv */
module tknd_front import tknd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  output logic        push,
  output tknd_entry_t push_entry,
  input  logic        q_full
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_ESC       = 4'd1;
  localparam logic [3:0] PH_CSI_NUM   = 4'd2;
  localparam logic [3:0] PH_CSI_MOD   = 4'd3;
  localparam logic [3:0] PH_TILDE_MOD = 4'd5;
  localparam logic [3:0] PH_SS3       = 4'd6;
  localparam logic [3:0] PH_T_SB      = 4'd7;
  localparam logic [3:0] PH_T_NAWS    = 4'd8;
  localparam logic [3:0] PH_T_WH      = 4'd9;
  localparam logic [3:0] PH_T_WL      = 4'd10;
  localparam logic [3:0] PH_T_HH      = 4'd11;
  localparam logic [3:0] PH_T_HL      = 4'd12;
  localparam logic [3:0] PH_T_IAC     = 4'd13;
  localparam logic [3:0] PH_T_SE      = 4'd14;

  localparam logic [7:0] CH_IAC    = 8'd255;
  localparam logic [7:0] CH_SB     = 8'd250;
  localparam logic [7:0] CH_NAWS   = 8'd31;
  localparam logic [7:0] CH_SE     = 8'd240;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  localparam logic [2:0] MOD_SHIFT = 3'b001;
  localparam logic [2:0] MOD_CTRL  = 3'b100;

  localparam logic [9:0] NUM_SAT = 10'd999;

  logic [3:0]  phase, phase_next;
  logic [9:0]  num_acc, num_acc_next;
  logic [9:0]  mod_acc, mod_acc_next;
  logic [9:0]  lead_num, lead_num_next;
  logic [15:0] width_hold, width_hold_next;
  logic [15:0] height_hold, height_hold_next;

  logic        accept;
  logic        is_digit;
  logic        idle_go;
  logic [8:0]  letter_key;
  tknd_entry_t ent;

  function automatic logic [9:0] add_digit(input logic [9:0] acc, input logic [7:0] b);
    logic [13:0] v;
    v = {4'b0, acc} * 14'd10 + {10'b0, b[3:0]};
    return (v > 14'(NUM_SAT)) ? NUM_SAT : v[9:0];
  endfunction

  function automatic logic [8:0] csi_letter(input logic [7:0] b);
    case (b)
      8'h41:   return K_UP;
      8'h42:   return K_DOWN;
      8'h43:   return K_RIGHT;
      8'h44:   return K_LEFT;
      8'h50:   return K_F1;
      8'h51:   return K_F1 + 9'd1;
      8'h52:   return K_F1 + 9'd2;
      8'h53:   return K_F1 + 9'd3;
      8'h48:   return K_HOME;
      8'h46:   return K_END;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [8:0] tilde_key(input logic [9:0] n);
    case (n)
      10'd2:   return K_INSERT;
      10'd3:   return K_DELETE;
      10'd4:   return K_END;
      10'd5:   return K_PGUP;
      10'd6:   return K_PGDN;
      10'd15:  return K_F1 + 9'd4;
      10'd17:  return K_F1 + 9'd5;
      10'd18:  return K_F1 + 9'd6;
      10'd19:  return K_F1 + 9'd7;
      10'd20:  return K_F1 + 9'd8;
      10'd21:  return K_F1 + 9'd9;
      10'd23:  return K_F1 + 9'd10;
      10'd24:  return K_F1 + 9'd11;
      default: return 9'd0;
    endcase
  endfunction

  assign s_tready   = !q_full;
  assign accept     = s_tvalid && s_tready;
  assign is_digit   = (s_tdata inside {[8'h30:8'h39]});
  assign letter_key = csi_letter(s_tdata);
  assign push       = accept && (ent.esc || ent.main);
  assign push_entry = ent;

  always_comb begin
    phase_next       = phase;
    num_acc_next     = num_acc;
    mod_acc_next     = mod_acc;
    lead_num_next    = lead_num;
    width_hold_next  = width_hold;
    height_hold_next = height_hold;
    idle_go          = 1'b0;
    ent              = '0;

    case (phase)
      PH_ESC: begin
        if (s_tdata == CH_LBRACK) begin
          num_acc_next = '0;
          phase_next   = PH_CSI_NUM;
        end else if (s_tdata == CH_O) begin
          phase_next = PH_SS3;
        end else begin
          // escape goes out first, then the byte is decoded afresh
          ent.esc = 1'b1;
          idle_go = 1'b1;
        end
      end
      PH_CSI_NUM: begin
        if (is_digit) begin
          num_acc_next = add_digit(num_acc, s_tdata);
        end else begin
          phase_next   = PH_IDLE;
          mod_acc_next = '0;
          if (num_acc == 10'd1) begin
            if (s_tdata == CH_TILDE) begin
              ent.main   = 1'b1;
              ent.ev.key = K_HOME;
            end else if (s_tdata == CH_SEMI) begin
              phase_next = PH_CSI_MOD;
            end
          end else if (num_acc == 10'd0) begin
            ent.main   = (letter_key != 9'd0);
            ent.ev.key = letter_key;
          end else begin
            lead_num_next = num_acc;
            if (s_tdata == CH_TILDE) begin
              ent.main   = 1'b1;
              ent.ev.key = tilde_key(num_acc);
            end else if (s_tdata == CH_SEMI) begin
              phase_next = PH_TILDE_MOD;
            end
          end
        end
      end
      PH_CSI_MOD: begin
        if (is_digit) begin
          mod_acc_next = add_digit(mod_acc, s_tdata);
        end else begin
          phase_next  = PH_IDLE;
          ent.main    = (letter_key != 9'd0);
          ent.ev.key  = letter_key;
          ent.ev.mods = mod_acc[2:0] - 3'd1;
        end
      end
      PH_TILDE_MOD: begin
        if (is_digit) begin
          mod_acc_next = add_digit(mod_acc, s_tdata);
        end else begin
          phase_next  = PH_IDLE;
          ent.main    = (s_tdata == CH_TILDE);
          ent.ev.key  = tilde_key(lead_num);
          ent.ev.mods = mod_acc[2:0] - 3'd1;
        end
      end
      PH_SS3: begin
        phase_next = PH_IDLE;
        if (s_tdata inside {[8'h50:8'h53]}) begin
          ent.main   = 1'b1;
          ent.ev.key = K_F1 + {7'b0, s_tdata[1:0]};
        end
      end
      PH_T_SB: begin
        phase_next = (s_tdata == CH_SB) ? PH_T_NAWS : PH_IDLE;
      end
      PH_T_NAWS: begin
        phase_next = (s_tdata == CH_NAWS) ? PH_T_WH : PH_IDLE;
      end
      PH_T_WH: begin
        width_hold_next = {s_tdata, 8'h00};
        phase_next      = PH_T_WL;
      end
      PH_T_WL: begin
        width_hold_next = {width_hold[15:8], s_tdata};
        phase_next      = PH_T_HH;
      end
      PH_T_HH: begin
        height_hold_next = {s_tdata, 8'h00};
        phase_next       = PH_T_HL;
      end
      PH_T_HL: begin
        height_hold_next = {height_hold[15:8], s_tdata};
        phase_next       = PH_T_IAC;
      end
      PH_T_IAC: begin
        phase_next = (s_tdata == CH_IAC) ? PH_T_SE : PH_IDLE;
      end
      PH_T_SE: begin
        phase_next = PH_IDLE;
        if (s_tdata == CH_SE) begin
          ent.main      = 1'b1;
          ent.ev.kind   = KIND_RESIZE;
          ent.ev.width  = width_hold;
          ent.ev.height = height_hold;
        end
      end
      default: begin
        idle_go = 1'b1;
      end
    endcase

    if (idle_go) begin
      phase_next = PH_IDLE;
      if (s_tdata == CH_IAC) begin
        phase_next = PH_T_SB;
      end else if (s_tdata == CH_ESC) begin
        if (s_tlast) begin
          ent.main   = 1'b1;
          ent.ev.key = K_ESCAPE;
        end else begin
          phase_next = PH_ESC;
        end
      end else if (s_tdata == CH_TAB) begin
        ent.main   = 1'b1;
        ent.ev.key = K_TAB;
      end else if (s_tdata inside {[8'd1:8'd26]}) begin
        // ctrl plus lower-case letter
        ent.main    = 1'b1;
        ent.ev.key  = {1'b0, s_tdata + 8'd96};
        ent.ev.mods = MOD_CTRL;
      end else if (s_tdata inside {[8'h41:8'h5A]}) begin
        ent.main    = 1'b1;
        ent.ev.key  = {1'b0, s_tdata + 8'd32};
        ent.ev.mods = MOD_SHIFT;
      end else begin
        ent.main   = 1'b1;
        ent.ev.key = {1'b0, s_tdata};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      num_acc     <= '0;
      mod_acc     <= '0;
      lead_num    <= '0;
      width_hold  <= '0;
      height_hold <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      num_acc     <= num_acc_next;
      mod_acc     <= mod_acc_next;
      lead_num    <= lead_num_next;
      width_hold  <= width_hold_next;
      height_hold <= height_hold_next;
    end
  end

endmodule

/* design/tknd_back.sv */
`include "assert_macros.svh"

module tknd_back import tknd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tknd_entry_t head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output tknd_event_t out_ev,
  output logic        out_last
);

  localparam tknd_event_t ESCAPE_EV = '{
    kind:   KIND_KEY,
    key:    K_ESCAPE,
    mods:   3'b000,
    width:  16'd0,
    height: 16'd0
  };

  logic advance;
  logic esc_now;
  // set once the escape of a pair has gone out and the main event is still queued
  logic esc_done;

  assign advance = !out_valid || out_ready;
  assign esc_now = head.esc && !esc_done;
  assign pop     = advance && !q_empty && !(esc_now && head.main);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      esc_done  <= 1'b0;
    end else if (advance) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        esc_done <= esc_now && head.main;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_empty) begin
      if (esc_now) begin
        out_ev   <= ESCAPE_EV;
        out_last <= !head.main;
      end else begin
        out_ev   <= head.ev;
        out_last <= 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_pair_split, clk, rst, out_valid && !out_last, esc_done, "escape shown without main event pending")
  `ASSERT_IMPLIES(a_pending_main, clk, rst, esc_done, !q_empty && head.esc && head.main, "pending main event lost from queue head")

endmodule

/* design/terminal_key_and_naws_decoder_unit.sv */
// channel | dir | tdata (low bit up)                              | tuser      | tlast
// s_      | in  | data_byte[7:0]                                  | -          | chunk_end
// m_      | out | key_code, shift, alt, ctrl, width, height, fill | event_kind | last_result
//
// one byte accepted per cycle while the queue is not full; a byte that yields an escape
// plus a second event gives two results on the result side, every other byte at most one
// m_tvalid rises once the event has passed the queue write and then the output register
// the four-entry queue between the parser and the output register absorbs stalls;
// s_tready drops only while it is full
// rst is synchronous and returns the parser to idle and empties the queue
module terminal_key_and_naws_decoder_unit import tknd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // key_code[8:0], shift_mod[9], alt_mod[10], ctrl_mod[11],
                                 // term_width[27:12], term_height[43:28], zero fill
  output logic        m_tuser,   // event_kind[0]
  output logic        m_tlast
);

  logic        push;
  tknd_entry_t push_entry;
  logic        q_full;
  logic        q_empty;
  logic        pop;
  tknd_entry_t head;
  tknd_event_t out_ev;

  tknd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  tknd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  tknd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ev    (out_ev),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0, out_ev.height, out_ev.width, out_ev.mods, out_ev.key};
  assign m_tuser = out_ev.kind;

endmodule

/* test/terminal_key_bytes_pkg.sv */
`timescale 1ns / 100ps

package terminal_key_bytes_pkg;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_CSI  = "[";
  localparam logic [7:0] CH_SS3  = "O";
  localparam logic [7:0] CH_SEMI = ";";
  localparam logic [7:0] CH_TILD = "~";
  localparam logic [7:0] TN_IAC  = 8'hFF;
  localparam logic [7:0] TN_SB   = 8'hFA;
  localparam logic [7:0] TN_NAWS = 8'h1F;
  localparam logic [7:0] TN_SE   = 8'hF0;

endpackage

/* test/terminal_key_and_naws_decoder_checker.sv */
`timescale 1ns / 100ps

module terminal_key_and_naws_decoder_checker
  import tknd_pkg::*;
  import terminal_key_bytes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          outstanding,
  output int          checked_count
);

  localparam logic [2:0] MOD_NONE  = 3'b000;
  localparam logic [2:0] MOD_SHIFT = 3'b001;
  localparam logic [2:0] MOD_CTRL  = 3'b100;

  typedef enum logic [3:0] {
    AT_TEXT, AT_ESCAPE, AT_CSI_PARAM, AT_CSI_MOD, AT_TILDE_MOD, AT_SS3,
    AT_TN_SB, AT_TN_OPT, AT_WIDTH_HI, AT_WIDTH_LO, AT_HEIGHT_HI, AT_HEIGHT_LO,
    AT_TN_IAC, AT_TN_SE
  } parse_at_t;

  typedef struct {
    logic        kind;
    logic [8:0]  key;
    logic [2:0]  mods;
    logic [15:0] width;
    logic [15:0] height;
    logic        last;
  } key_report_t;

  parse_at_t   parse_at;
  logic [9:0]  number_acc;
  logic [9:0]  modifier_acc;
  logic [9:0]  lead_code;
  logic [15:0] width_acc;
  logic [15:0] height_acc;

  key_report_t report_q[$];
  key_report_t fresh[$];
  int          mismatches;
  int          checked;

  function automatic logic [9:0] push_digit(logic [9:0] acc, logic [7:0] b);
    int v;
    v = int'(acc) * 10 + int'(b - "0");
    return (v > 999) ? 10'd999 : v[9:0];
  endfunction

  // modifier m encodes m-1; zero wraps round to all three set
  function automatic logic [2:0] modifier_mods(logic [9:0] acc);
    logic [9:0] t;
    t = acc - 10'd1;
    return t[2:0];
  endfunction

  function automatic logic [8:0] csi_final_key(logic [7:0] b);
    case (b)
      "A": return K_UP;
      "B": return K_DOWN;
      "C": return K_RIGHT;
      "D": return K_LEFT;
      "P": return K_F1;
      "Q": return K_F1 + 9'd1;
      "R": return K_F1 + 9'd2;
      "S": return K_F1 + 9'd3;
      "H": return K_HOME;
      "F": return K_END;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [8:0] tilde_code_key(logic [9:0] n);
    case (n)
      10'd2:  return K_INSERT;
      10'd3:  return K_DELETE;
      10'd4:  return K_END;
      10'd5:  return K_PGUP;
      10'd6:  return K_PGDN;
      10'd15: return K_F1 + 9'd4;
      10'd17: return K_F1 + 9'd5;
      10'd18: return K_F1 + 9'd6;
      10'd19: return K_F1 + 9'd7;
      10'd20: return K_F1 + 9'd8;
      10'd21: return K_F1 + 9'd9;
      10'd23: return K_F1 + 9'd10;
      10'd24: return K_F1 + 9'd11;
      default: return 9'd0;
    endcase
  endfunction

  task automatic add_key(logic [8:0] key, logic [2:0] mods);
    key_report_t r;
    r.kind   = KIND_KEY;
    r.key    = key;
    r.mods   = mods;
    r.width  = 16'd0;
    r.height = 16'd0;
    r.last   = 1'b0;
    fresh.push_back(r);
  endtask

  task automatic decode_text(logic [7:0] b, logic ce);
    parse_at = AT_TEXT;
    if (b == TN_IAC) begin
      parse_at = AT_TN_SB;
    end else if (b == CH_ESC) begin
      if (ce) add_key(K_ESCAPE, MOD_NONE);
      else parse_at = AT_ESCAPE;
    end else if (b == CH_TAB) begin
      add_key(K_TAB, MOD_NONE);
    end else if (b >= 8'd1 && b <= 8'd26) begin
      add_key({1'b0, b - 8'd1 + "a"}, MOD_CTRL);
    end else if (b >= "A" && b <= "Z") begin
      add_key({1'b0, b - "A" + "a"}, MOD_SHIFT);
    end else begin
      add_key({1'b0, b}, MOD_NONE);
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic ce);
    logic       is_digit;
    logic [8:0] k;
    key_report_t r;
    is_digit = (b >= "0" && b <= "9");
    fresh.delete();
    case (parse_at)
      AT_ESCAPE: begin
        if (b == CH_CSI) begin
          number_acc = 10'd0;
          parse_at = AT_CSI_PARAM;
        end else if (b == CH_SS3) begin
          parse_at = AT_SS3;
        end else begin
          add_key(K_ESCAPE, MOD_NONE);
          decode_text(b, ce);
        end
      end
      AT_CSI_PARAM: begin
        if (is_digit) begin
          number_acc = push_digit(number_acc, b);
        end else begin
          parse_at = AT_TEXT;
          modifier_acc = 10'd0;
          if (number_acc == 10'd1) begin
            if (b == CH_TILD) add_key(K_HOME, MOD_NONE);
            else if (b == CH_SEMI) parse_at = AT_CSI_MOD;
          end else if (number_acc == 10'd0) begin
            k = csi_final_key(b);
            if (k != 9'd0) add_key(k, MOD_NONE);
          end else begin
            lead_code = number_acc;
            if (b == CH_TILD) add_key(tilde_code_key(lead_code), MOD_NONE);
            else if (b == CH_SEMI) parse_at = AT_TILDE_MOD;
          end
        end
      end
      AT_CSI_MOD: begin
        if (is_digit) begin
          modifier_acc = push_digit(modifier_acc, b);
        end else begin
          parse_at = AT_TEXT;
          k = csi_final_key(b);
          if (k != 9'd0) add_key(k, modifier_mods(modifier_acc));
        end
      end
      AT_TILDE_MOD: begin
        if (is_digit) begin
          modifier_acc = push_digit(modifier_acc, b);
        end else begin
          parse_at = AT_TEXT;
          if (b == CH_TILD) add_key(tilde_code_key(lead_code), modifier_mods(modifier_acc));
        end
      end
      AT_SS3: begin
        parse_at = AT_TEXT;
        if (b >= "P" && b <= "S") add_key(K_F1 + {1'b0, b - "P"}, MOD_NONE);
      end
      AT_TN_SB:     parse_at = (b == TN_SB) ? AT_TN_OPT : AT_TEXT;
      AT_TN_OPT:    parse_at = (b == TN_NAWS) ? AT_WIDTH_HI : AT_TEXT;
      AT_WIDTH_HI: begin
        width_acc = {b, 8'h00};
        parse_at = AT_WIDTH_LO;
      end
      AT_WIDTH_LO: begin
        width_acc[7:0] = b;
        parse_at = AT_HEIGHT_HI;
      end
      AT_HEIGHT_HI: begin
        height_acc = {b, 8'h00};
        parse_at = AT_HEIGHT_LO;
      end
      AT_HEIGHT_LO: begin
        height_acc[7:0] = b;
        parse_at = AT_TN_IAC;
      end
      AT_TN_IAC:    parse_at = (b == TN_IAC) ? AT_TN_SE : AT_TEXT;
      AT_TN_SE: begin
        parse_at = AT_TEXT;
        if (b == TN_SE) begin
          r.kind   = KIND_RESIZE;
          r.key    = 9'd0;
          r.mods   = MOD_NONE;
          r.width  = width_acc;
          r.height = height_acc;
          r.last   = 1'b0;
          fresh.push_back(r);
        end
      end
      default: decode_text(b, ce);
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) report_q.push_back(fresh[i]);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    key_report_t want;
    if (rst) begin
      parse_at     = AT_TEXT;
      number_acc   = 10'd0;
      modifier_acc = 10'd0;
      lead_code    = 10'd0;
      width_acc    = 16'd0;
      height_acc   = 16'd0;
      report_q.delete();
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (report_q.size() == 0) begin
          $error("event_kind: expected none, got %0d (unexpected result transaction)",
                 m_tuser);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          checked++;
          check_field("event_kind", want.kind, m_tuser);
          check_field("key_code", want.key, m_tdata[8:0]);
          check_field("shift_mod", want.mods[0], m_tdata[9]);
          check_field("alt_mod", want.mods[1], m_tdata[10]);
          check_field("ctrl_mod", want.mods[2], m_tdata[11]);
          check_field("term_width", want.width, m_tdata[27:12]);
          check_field("term_height", want.height, m_tdata[43:28]);
          check_field("last_result", want.last, m_tlast);
        end
      end
    end
    fail_count    <= mismatches;
    outstanding   <= report_q.size();
    checked_count <= checked;
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import terminal_key_bytes_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // data_byte[7:0]
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;          // key_code, shift, alt, ctrl, term_width, term_height
  logic        m_tuser;          // event_kind
  logic        m_tlast;

  int fail_count;
  int outstanding;
  int checked_count;

  int idle_pct = 0;
  int stall_pct = 0;
  int sent_bytes = 0;

  logic [7:0] seq_data[$];
  logic       seq_end[$];

  int tilde_codes[13] = '{2, 3, 4, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
  string csi_finals = "ABCDPQRSHF";

  terminal_key_and_naws_decoder_unit dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  terminal_key_and_naws_decoder_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .fail_count, .outstanding, .checked_count
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_byte(logic [7:0] b, logic ce);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= ce;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic add(logic [7:0] b, logic ce = 1'b0);
    seq_data.push_back(b);
    seq_end.push_back(ce);
  endtask

  task automatic flush_seq();
    foreach (seq_data[i]) send_byte(seq_data[i], seq_end[i]);
    seq_data.delete();
    seq_end.delete();
  endtask

  task automatic add_number(int n);
    string s;
    s = $sformatf("%0d", n);
    if ($urandom_range(7) == 0) add("0");
    for (int i = 0; i < s.len(); i++) add(s[i]);
  endtask

  function automatic int pick_modifier();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(20000);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // hold the sender until the last expected event has gone out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic make_sequence();
    int n;
    case ($urandom_range(12))
      0, 1: add(8'($urandom_range(255)));
      2: add(CH_ESC, 1'b1);
      3: begin
        add(CH_ESC);
        add(8'($urandom_range(255)));
      end
      4: begin
        add(CH_ESC);
        add(CH_CSI);
        if ($urandom_range(4) == 0) add(8'($urandom_range(255)));
        else add(csi_finals[$urandom_range(9)]);
      end
      5: begin
        add(CH_ESC);
        add(CH_CSI);
        add("1");
        add(CH_SEMI);
        add_number(pick_modifier());
        add(csi_finals[$urandom_range(9)]);
      end
      6, 7: begin
        add(CH_ESC);
        add(CH_CSI);
        add_number(($urandom_range(3) == 0) ? $urandom_range(40)
                                            : tilde_codes[$urandom_range(12)]);
        if ($urandom_range(1)) begin
          add(CH_SEMI);
          add_number(pick_modifier());
        end
        add(CH_TILD);
      end
      8: begin
        // long parameters can push the accumulators into saturation
        add(CH_ESC);
        add(CH_CSI);
        add_number($urandom_range(1000000));
        if ($urandom_range(1)) begin
          add(CH_SEMI);
          add_number($urandom_range(1000000));
        end
        add(CH_TILD);
      end
      9: begin
        add(CH_ESC);
        add(CH_SS3);
        add(8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range("P", "S")));
      end
      10, 11: begin
        add(TN_IAC);
        add(TN_SB);
        add(TN_NAWS);
        repeat (4) add(8'($urandom_range(255)));
        add(TN_IAC);
        add(TN_SE);
      end
      default: begin
        add(CH_ESC);
        add(CH_CSI);
        add("1");
        add(8'($urandom_range(255)));
      end
    endcase
    foreach (seq_end[i])
      if (seq_data[i] != CH_ESC || i == seq_data.size() - 1)
        seq_end[i] = seq_end[i] | ($urandom_range(15) == 0);
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(seq_data.size() - 1);
      seq_data[n] = 8'($urandom_range(255));
    end
    if (seq_data.size() > 1 && $urandom_range(11) == 0) begin
      n = $urandom_range(1, seq_data.size() - 1);
      while (seq_data.size() > n) begin
        void'(seq_data.pop_back());
        void'(seq_end.pop_back());
      end
    end
  endtask

  initial begin
    int start;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain bytes, tab, ctrl and shift mapping
    add(8'h00); add(CH_TAB); add(8'h01, 1'b1); add(8'h1A); add("A"); add("Z");
    add(8'h80); add(8'hFE);
    // lone escape, then escape followed by an ordinary byte
    add(CH_ESC, 1'b1);
    add(CH_ESC); add("q");
    // ctrl+right, home with chunk end inside, malformed after 1, ss3 f4
    add(CH_ESC); add(CH_CSI); add("1"); add(CH_SEMI); add("5"); add("C");
    add(CH_ESC); add(CH_CSI); add("1"); add(CH_TILD, 1'b1);
    add(CH_ESC); add(CH_CSI); add("1"); add("x");
    add(CH_ESC); add(CH_SS3); add("S");
    add(TN_IAC); add(TN_SB); add(TN_NAWS); add(8'hFF); add(8'hFF); add(8'h00); add(8'h00);
    add(TN_IAC); add(TN_SE);
    flush_seq();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      start = sent_bytes;
      while (sent_bytes - start < 100) begin
        make_sequence();
        flush_seq();
      end
      drain();
    end

    stall_pct = 0;
    repeat (12) @(posedge clk);
    $display("sent %0d bytes over four idle/stall phases, %0d events checked",
             sent_bytes, checked_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[terminal_key_and_naws_decoder_unit] OK");
    end else begin
      $display("[terminal_key_and_naws_decoder_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[terminal_key_and_naws_decoder_unit] ERROR");
    $finish;
  end

endmodule
